### hdl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### hdl/wavhp_pkg.sv
// Shared types and constants for the WAV header parser.
// No dependencies; used by every module of the block.
package wavhp_pkg;

  localparam int unsigned MAX_CHUNKS     = 1024;
  localparam int unsigned MAX_FILE_BYTES = 1073741824;

  localparam int unsigned OFS_W  = 31;   // byte offset, holds MAX_FILE_BYTES
  localparam int unsigned POS_W  = 33;   // RIFF positions, size field + 8
  localparam int unsigned CNT_W  = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned FMT_BYTES = 16;
  localparam int unsigned FILL_W = $clog2(FMT_BYTES);

  localparam int unsigned RIFF_SIZE_LAST = 7;   // last byte of the RIFF size field
  localparam int unsigned HDR_LAST       = 11;  // last byte of the file header
  localparam int unsigned HDR_BYTES      = 12;
  localparam int unsigned CHUNK_HDR      = 8;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM  = 16'd1;
  localparam logic [31:0] RATE_MIN = 32'd8000;
  localparam logic [31:0] RATE_MAX = 32'd48000;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_NOT_RIFF  = 2'd1,
    ST_SIZE      = 2'd2,
    ST_INVALID   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_HEAD   = 3'd1,
    PH_BODY   = 3'd2,
    PH_FMT    = 3'd3,
    PH_DONE   = 3'd4,
    PH_STOP   = 3'd5
  } parse_phase_e;

  // Parser state captured on the final byte of a file.
  typedef struct packed {
    logic             oversize;
    logic             too_short;
    status_e          bad;
    logic             done;
    logic [POS_W-1:0] next_at;
    logic [POS_W-1:0] riff_end;
    logic [OFS_W-1:0] size;
    logic             fmt_seen;
    logic             data_seen;
    logic [OFS_W-1:0] data_start;
    logic [31:0]      data_len;
    logic [1:0]       chan;
    logic [15:0]      rate;
    logic [4:0]       bits;
  } wavhp_snap_t;

endpackage

### hdl/wav_header_parser.sv
// Top level of the RIFF/WAVE PCM header parser.
// Depends on wavhp_pkg, wavhp_fmt_check, wavhp_result and assert_macros.svh.
//
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o  | data_byte_i, end_of_file_i
//  out     | out_valid_o / out_stall_i| status_o, channel_count_o, sample_rate_o,
//          |                          | sample_bits_o, data_offset_o, frame_count_o
//
// One byte per cycle unless a final byte is held back: each beat sits in the
// input register while the parser state updates from it. The final byte's
// state goes to a snapshot register, and its result moves on to the output
// register once that is free. Reset is asynchronous, active low, and needs no
// clearing pass. A stalled output holds back only a final byte; other bytes
// keep flowing while a result waits.
`include "assert_macros.svh"

module wav_header_parser import wavhp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_file_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [1:0]       channel_count_o,
  output logic [15:0]      sample_rate_o,
  output logic [4:0]       sample_bits_o,
  output logic [OFS_W-1:0] data_offset_o,
  output logic [OFS_W-1:0] frame_count_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       eof_q;

  // parser state
  logic [OFS_W-1:0]       offset_q, offset_d;
  logic [POS_W-1:0]       riff_end_q, riff_end_d;
  logic [POS_W-1:0]       next_q, next_d;
  logic [63:0]            shift_q, shift_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [8*FMT_BYTES-1:0] fmt_q, fmt_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic                   fmt_seen_q, fmt_seen_d;
  logic                   data_seen_q, data_seen_d;
  logic [OFS_W-1:0]       start_q, start_d;
  logic [31:0]            len_q, len_d;
  status_e                bad_q, bad_d;
  parse_phase_e           phase_q, phase_d;

  logic        snap_free, step, accept;
  wavhp_snap_t snap;

  logic                   live;
  logic [63:0]            shift_nx;
  logic [8*FMT_BYTES-1:0] fmt_nx;
  logic                   fmt_good;
  logic [31:0]            chunk_id, chunk_len;
  logic [POS_W:0]         ofs_ext, next_ext, hdr_last, body_at;
  logic [POS_W-1:0]       room, next_after;
  logic                   too_long, fits_here, fits_empty, body_end;
  logic                   cnt_room, cnt_room_nx;
  parse_phase_e           begin_phase;

  // a final byte needs the snapshot register; other bytes always move on
  assign step       = in_valid_q && (!eof_q || snap_free);
  assign in_stall_o = in_valid_q && !step;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      eof_q  <= end_of_file_i;
    end
  end

  wavhp_fmt_check u_fmt_check (
    .fmt_body_i (fmt_nx),
    .fmt_ok_o   (fmt_good)
  );

  assign live      = offset_q < OFS_W'(MAX_FILE_BYTES);
  assign shift_nx  = {byte_q, shift_q[63:8]};
  assign fmt_nx    = {byte_q, fmt_q[8*FMT_BYTES-1:8]};
  assign chunk_id  = shift_nx[31:0];
  assign chunk_len = shift_nx[63:32];

  // position terms, all taken from registered state
  assign ofs_ext    = (POS_W+1)'(offset_q);
  assign next_ext   = {1'b0, next_q};
  assign hdr_last   = next_ext + (POS_W+1)'(CHUNK_HDR - 1);
  assign body_at    = next_ext + (POS_W+1)'(CHUNK_HDR);
  assign room       = riff_end_q - body_at[POS_W-1:0];
  assign too_long   = {1'b0, chunk_len} > room;
  assign next_after = body_at[POS_W-1:0] + {1'b0, chunk_len} + POS_W'(chunk_len[0]);
  assign fits_here  = body_at <= {1'b0, riff_end_q};
  assign fits_empty = next_ext + (POS_W+1)'(2 * CHUNK_HDR) <= {1'b0, riff_end_q};
  assign body_end   = ofs_ext + (POS_W+1)'(1) >= next_ext;
  assign cnt_room    = count_q < CNT_W'(MAX_CHUNKS);
  assign cnt_room_nx = {1'b0, count_q} + (CNT_W+1)'(1) < (CNT_W+1)'(MAX_CHUNKS);
  assign begin_phase = (fits_here && cnt_room) ? PH_HEAD : PH_DONE;

  always_comb begin
    offset_d    = offset_q;
    riff_end_d  = riff_end_q;
    next_d      = next_q;
    shift_d     = shift_q;
    count_d     = count_q;
    fmt_d       = fmt_q;
    fill_d      = fill_q;
    fmt_seen_d  = fmt_seen_q;
    data_seen_d = data_seen_q;
    start_d     = start_q;
    len_d       = len_q;
    bad_d       = bad_q;
    phase_d     = phase_q;
    if (live) begin
      offset_d = offset_q + OFS_W'(1);
      shift_d  = shift_nx;
      unique case (phase_q)
        PH_HEADER: begin
          if (offset_q == OFS_W'(RIFF_SIZE_LAST)) begin
            if (chunk_id != TAG_RIFF) begin
              bad_d   = ST_NOT_RIFF;
              phase_d = PH_STOP;
            end else begin
              riff_end_d = {1'b0, chunk_len} + POS_W'(CHUNK_HDR);
            end
          end else if (offset_q == OFS_W'(HDR_LAST)) begin
            if (chunk_len != TAG_WAVE) begin
              bad_d   = ST_NOT_RIFF;
              phase_d = PH_STOP;
            end else begin
              next_d  = POS_W'(HDR_BYTES);
              phase_d = (riff_end_q >= POS_W'(HDR_BYTES + CHUNK_HDR) && cnt_room) ?
                        PH_HEAD : PH_DONE;
            end
          end
        end
        PH_HEAD: begin
          if (ofs_ext == hdr_last) begin
            count_d = count_q + CNT_W'(1);
            if (too_long) begin
              bad_d   = ST_INVALID;
              phase_d = PH_STOP;
            end else begin
              next_d = next_after;
              if (chunk_id == TAG_FMT) begin
                if (fmt_seen_q || chunk_len < 32'(FMT_BYTES)) begin
                  bad_d   = ST_INVALID;
                  phase_d = PH_STOP;
                end else begin
                  fill_d  = '0;
                  phase_d = PH_FMT;
                end
              end else if (chunk_id == TAG_DATA && data_seen_q) begin
                bad_d   = ST_INVALID;
                phase_d = PH_STOP;
              end else begin
                if (chunk_id == TAG_DATA) begin
                  data_seen_d = 1'b1;
                  start_d     = body_at[OFS_W-1:0];
                  len_d       = chunk_len;
                end
                // empty body: the next header starts right away
                if (chunk_len == 32'd0) begin
                  phase_d = (fits_empty && cnt_room_nx) ? PH_HEAD : PH_DONE;
                end else begin
                  phase_d = PH_BODY;
                end
              end
            end
          end
        end
        PH_FMT: begin
          fmt_d  = fmt_nx;
          fill_d = fill_q + FILL_W'(1);
          if (fill_q == FILL_W'(FMT_BYTES - 1)) begin
            if (!fmt_good) begin
              bad_d   = ST_INVALID;
              phase_d = PH_STOP;
            end else begin
              fmt_seen_d = 1'b1;
              phase_d    = body_end ? begin_phase : PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (body_end) begin
            phase_d = begin_phase;
          end
        end
        PH_DONE, PH_STOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // a final beat starts the next file from the reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      riff_end_q  <= '0;
      next_q      <= POS_W'(HDR_BYTES);
      count_q     <= '0;
      fill_q      <= '0;
      fmt_seen_q  <= 1'b0;
      data_seen_q <= 1'b0;
      bad_q       <= ST_VALID;
      phase_q     <= PH_HEADER;
    end else if (step) begin
      if (eof_q) begin
        offset_q    <= '0;
        riff_end_q  <= '0;
        next_q      <= POS_W'(HDR_BYTES);
        count_q     <= '0;
        fill_q      <= '0;
        fmt_seen_q  <= 1'b0;
        data_seen_q <= 1'b0;
        bad_q       <= ST_VALID;
        phase_q     <= PH_HEADER;
      end else begin
        offset_q    <= offset_d;
        riff_end_q  <= riff_end_d;
        next_q      <= next_d;
        count_q     <= count_d;
        fill_q      <= fill_d;
        fmt_seen_q  <= fmt_seen_d;
        data_seen_q <= data_seen_d;
        bad_q       <= bad_d;
        phase_q     <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      shift_q <= shift_d;
      fmt_q   <= fmt_d;
      start_q <= start_d;
      len_q   <= len_d;
    end
  end

  always_comb begin
    snap.oversize  = !live;
    snap.too_short = offset_q < OFS_W'(HDR_LAST);
    snap.bad       = bad_d;
    snap.done      = phase_d == PH_DONE;
    snap.next_at   = next_d;
    snap.riff_end  = riff_end_d;
    snap.size      = offset_q + OFS_W'(1);
    snap.fmt_seen  = fmt_seen_d;
    snap.data_seen = data_seen_d;
    snap.data_start = start_d;
    snap.data_len  = len_d;
    snap.chan      = fmt_d[17:16];
    snap.rate      = fmt_d[47:32];
    snap.bits      = fmt_d[116:112];
  end

  wavhp_result u_result (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .snap_load_i     (step && eof_q),
    .snap_i          (snap),
    .snap_free_o     (snap_free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .channel_count_o (channel_count_o),
    .sample_rate_o   (sample_rate_o),
    .sample_bits_o   (sample_bits_o),
    .data_offset_o   (data_offset_o),
    .frame_count_o   (frame_count_o)
  );

  `ASSERT_RST(a_stop_iff_bad, clk_i, rst_ni, (phase_q == PH_STOP) == (bad_q != ST_VALID))
  `ASSERT_NEVER(a_fmt_twice, clk_i, rst_ni, phase_q == PH_FMT && fmt_seen_q)
  `ASSERT_RST(a_chunk_limit, clk_i, rst_ni, count_q <= CNT_W'(MAX_CHUNKS))
  `ASSERT_RST(a_eof_restart, clk_i, rst_ni, step && eof_q |=> offset_q == '0 && phase_q == PH_HEADER)

endmodule

### hdl/wavhp_fmt_check.sv
// PCM format check over the first 16 bytes of a fmt chunk body.
// Depends on wavhp_pkg.
module wavhp_fmt_check import wavhp_pkg::*; (
  input  logic [8*FMT_BYTES-1:0] fmt_body_i,
  output logic                   fmt_ok_o
);

  logic [15:0] tag, chans, align, bits;
  logic [31:0] rate, brate;
  logic        ch_ok, rate_ok, bits_ok;
  logic [1:0]  shamt;
  logic [15:0] align_exp;
  logic [31:0] brate_exp;

  assign tag   = fmt_body_i[15:0];
  assign chans = fmt_body_i[31:16];
  assign rate  = fmt_body_i[63:32];
  assign brate = fmt_body_i[95:64];
  assign align = fmt_body_i[111:96];
  assign bits  = fmt_body_i[127:112];

  assign ch_ok   = (chans == 16'd1) || (chans == 16'd2);
  assign rate_ok = (rate >= RATE_MIN) && (rate <= RATE_MAX);
  assign bits_ok = (bits == 16'd8) || (bits == 16'd16);

  // bytes per frame is 1, 2 or 4 once channels and bits are legal
  assign shamt     = {1'b0, chans == 16'd2} + {1'b0, bits == 16'd16};
  assign align_exp = 16'd1 << shamt;
  assign brate_exp = rate << shamt;

  assign fmt_ok_o = (tag == FMT_PCM) && ch_ok && rate_ok && bits_ok &&
                    (align == align_exp) && (brate == brate_exp);

endmodule

### hdl/wavhp_result.sv
// Result stage: end-of-file snapshot register, status decode, output register.
// Depends on wavhp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wavhp_result import wavhp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             snap_load_i,
  input  wavhp_snap_t      snap_i,
  output logic             snap_free_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [1:0]       channel_count_o,
  output logic [15:0]      sample_rate_o,
  output logic [4:0]       sample_bits_o,
  output logic [OFS_W-1:0] data_offset_o,
  output logic [OFS_W-1:0] frame_count_o
);

  logic        snap_valid_q, snap_valid_d;
  wavhp_snap_t snap_q;
  logic        out_valid_q, out_valid_d;
  logic        out_free, snap_move;

  logic [1:0]       shamt;
  logic [1:0]       frame_mask;
  logic             aligned, wav_ok;
  status_e          status_d;
  logic [1:0]       chan_d;
  logic [15:0]      rate_d;
  logic [4:0]       bits_d;
  logic [OFS_W-1:0] offset_d, frames_d;
  logic [31:0]      frames_full;

  logic [1:0]       status_q, chan_q;
  logic [15:0]      rate_q;
  logic [4:0]       bits_q;
  logic [OFS_W-1:0] offset_q, frames_q;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign snap_move   = snap_valid_q && out_free;
  assign snap_free_o = !snap_valid_q || out_free;

  always_comb begin
    snap_valid_d = snap_valid_q;
    if (snap_load_i) begin
      snap_valid_d = 1'b1;
    end else if (snap_move) begin
      snap_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (snap_move) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  // frame size is a power of two, so divide and remainder are shift and mask
  assign shamt = {1'b0, snap_q.chan == 2'd2} + {1'b0, snap_q.bits == 5'd16};

  always_comb begin
    unique case (shamt)
      2'd0:    frame_mask = 2'b00;
      2'd1:    frame_mask = 2'b01;
      default: frame_mask = 2'b11;
    endcase
  end

  assign aligned     = (snap_q.data_len[1:0] & frame_mask) == 2'b00;
  assign frames_full = snap_q.data_len >> shamt;

  assign wav_ok = (snap_q.bad == ST_VALID) && snap_q.done &&
                  (snap_q.next_at == snap_q.riff_end) &&
                  (snap_q.riff_end <= {2'b00, snap_q.size}) &&
                  snap_q.fmt_seen && snap_q.data_seen &&
                  (snap_q.data_len != 32'd0) && aligned;

  always_comb begin
    status_d = ST_INVALID;
    chan_d   = '0;
    rate_d   = '0;
    bits_d   = '0;
    offset_d = '0;
    frames_d = '0;
    priority if (snap_q.oversize || snap_q.too_short) begin
      status_d = ST_SIZE;
    end else if (snap_q.bad == ST_NOT_RIFF) begin
      status_d = ST_NOT_RIFF;
    end else if (wav_ok) begin
      status_d = ST_VALID;
      chan_d   = snap_q.chan;
      rate_d   = snap_q.rate;
      bits_d   = snap_q.bits;
      offset_d = snap_q.data_start;
      frames_d = frames_full[OFS_W-1:0];
    end else begin
      status_d = ST_INVALID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_load_i) begin
      snap_q <= snap_i;
    end
    if (snap_move) begin
      status_q <= status_d;
      chan_q   <= chan_d;
      rate_q   <= rate_d;
      bits_q   <= bits_d;
      offset_q <= offset_d;
      frames_q <= frames_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign channel_count_o = chan_q;
  assign sample_rate_o   = rate_q;
  assign sample_bits_o   = bits_q;
  assign data_offset_o   = offset_q;
  assign frame_count_o   = frames_q;

  `ASSERT_RST(a_fail_fields_zero, clk_i, rst_ni, out_valid_o && status_o != ST_VALID |-> channel_count_o == 2'd0 && sample_rate_o == 16'd0 && sample_bits_o == 5'd0 && frame_count_o == '0)
  `ASSERT_RST(a_valid_format, clk_i, rst_ni, out_valid_o && status_o == ST_VALID |-> (sample_bits_o == 5'd8 || sample_bits_o == 5'd16) && channel_count_o != 2'd0)
  `ASSERT_RST(a_snap_held, clk_i, rst_ni, snap_valid_q && out_valid_o && out_stall_i |=> snap_valid_q)

endmodule
